// ===== rtl/kfr_pkg.sv =====
package kfr_pkg;

  // default sizing
  localparam int MAX_FRAME_DEF     = 64;
  localparam int NUM_PATTERNS_DEF  = 4;
  localparam int PATTERN_BYTES_DEF = 8;

  // register port
  localparam int APB_AW = 6;
  localparam int APB_DW = 64;

  localparam logic [2:0] REG_PATTERN_A   = 3'd0;
  localparam logic [2:0] REG_PATTERN_B   = 3'd1;
  localparam logic [2:0] REG_PATTERN_C   = 3'd2;
  localparam logic [2:0] REG_PATTERN_D   = 3'd3;
  localparam logic [2:0] REG_LENGTHS     = 3'd4;
  localparam logic [2:0] REG_COUNT       = 3'd5;

  // protocol constants
  localparam logic [7:0] HEADER_BYTE = 8'h70;
  localparam logic [1:0] WAKE_LIMIT  = 2'd3;
  localparam int         MIN_END_LEN = 3;

  // result event codes
  localparam logic [2:0] EV_STORED   = 3'd0;
  localparam logic [2:0] EV_WAKE     = 3'd1;
  localparam logic [2:0] EV_HEADER   = 3'd2;
  localparam logic [2:0] EV_MATCH    = 3'd3;
  localparam logic [2:0] EV_NOMATCH  = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [3:0][63:0] pattern;
    logic [15:0]      lengths;
    logic [2:0]       count;
  } cfg_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic [1:0] index;
  } match_res_t;

endpackage

// ===== rtl/kfr_cfg_regs.sv =====
module kfr_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kfr_pkg::APB_AW-1:0] paddr,
  input  logic [kfr_pkg::APB_DW-1:0] pwdata,
  output logic [kfr_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output kfr_pkg::cfg_t             cfg
);
  import kfr_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[APB_AW-1:3];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_PATTERN_A: cfg.pattern[0] <= pwdata;
        REG_PATTERN_B: cfg.pattern[1] <= pwdata;
        REG_PATTERN_C: cfg.pattern[2] <= pwdata;
        REG_PATTERN_D: cfg.pattern[3] <= pwdata;
        REG_LENGTHS:   cfg.lengths    <= pwdata[15:0];
        REG_COUNT:     cfg.count      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PATTERN_A: prdata = cfg.pattern[0];
      REG_PATTERN_B: prdata = cfg.pattern[1];
      REG_PATTERN_C: prdata = cfg.pattern[2];
      REG_PATTERN_D: prdata = cfg.pattern[3];
      REG_LENGTHS:   prdata = {48'd0, cfg.lengths};
      REG_COUNT:     prdata = {61'd0, cfg.count};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/kfr_prefix_matcher.sv =====
module kfr_prefix_matcher #(
  parameter int MAX_FRAME     = kfr_pkg::MAX_FRAME_DEF,
  parameter int NUM_PATTERNS  = kfr_pkg::NUM_PATTERNS_DEF,
  parameter int PATTERN_BYTES = kfr_pkg::PATTERN_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [$clog2(MAX_FRAME+1)-1:0]   frame_len,
  input  kfr_pkg::cfg_t                    cfg,
  input  kfr_pkg::byte_t                   head [PATTERN_BYTES],
  output kfr_pkg::match_res_t              res
);
  import kfr_pkg::*;

  localparam int LW = $clog2(MAX_FRAME + 1);
  localparam int IW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam int BW = $clog2(PATTERN_BYTES + 1);
  localparam int PW = $clog2(NUM_PATTERNS + 1);

  logic          busy;
  logic [PW-1:0] pat;
  logic [BW-1:0] bix;
  logic [LW-1:0] len;
  logic [PW-1:0] n_use;

  logic [1:0] pidx;
  logic [3:0] nib;
  logic [3:0] plen;
  byte_t      want;
  byte_t      got;

  // one byte compare per cycle, walked over patterns and bytes
  always_comb begin
    pidx = 2'(pat);
    nib  = cfg.lengths[4*pidx +: 4];
    plen = (nib > 4'(PATTERN_BYTES)) ? 4'(PATTERN_BYTES) : nib;
    want = cfg.pattern[pidx][8*bix[IW-1:0] +: 8];
    got  = head[bix[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      if (start) begin
        res.done <= 1'b0;
        busy     <= 1'b1;
        pat      <= '0;
        bix      <= '0;
        len      <= frame_len;
        n_use    <= (cfg.count > 3'(NUM_PATTERNS)) ? PW'(NUM_PATTERNS) : PW'(cfg.count);
      end else if (busy) begin
        if (pat >= n_use) begin
          busy      <= 1'b0;
          res.done  <= 1'b1;
          res.hit   <= 1'b0;
          res.index <= 2'd0;
        end else if (LW'(plen) > len) begin
          // pattern longer than frame
          res.done <= 1'b0;
          pat      <= pat + 1'b1;
          bix      <= '0;
        end else if (4'(bix) == plen) begin
          busy      <= 1'b0;
          res.done  <= 1'b1;
          res.hit   <= 1'b1;
          res.index <= pidx;
        end else if (want == got) begin
          res.done <= 1'b0;
          bix      <= bix + 1'b1;
        end else begin
          res.done <= 1'b0;
          pat      <= pat + 1'b1;
          bix      <= '0;
        end
      end else begin
        res.done <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/kline_frame_receiver.sv =====
// K-line frame receiver: one received byte per item, one result item per byte.
// Result path: a byte that does not end a frame passes from S_IDLE to S_OUT, where
// the result is registered once the output is free; a frame end first runs the
// byte-serial prefix compare in S_MATCH before S_OUT.
// Throughput: one item at a time; rx_ready is high only while idle.
// Reset (rst, synchronous, active high) clears frame, wake and config state.
module kline_frame_receiver #(
  parameter int MAX_FRAME     = kfr_pkg::MAX_FRAME_DEF,
  parameter int NUM_PATTERNS  = kfr_pkg::NUM_PATTERNS_DEF,
  parameter int PATTERN_BYTES = kfr_pkg::PATTERN_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // received byte channel
  input  logic                        rx_valid,
  output logic                        rx_ready,
  input  logic [7:0]                  rx_byte,
  // result channel
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [2:0]                  event_res,
  output logic [1:0]                  match_index,
  output logic                        wake_active,
  output logic [6:0]                  frame_length,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kfr_pkg::APB_AW-1:0]  paddr,
  input  logic [kfr_pkg::APB_DW-1:0]  pwdata,
  output logic [kfr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import kfr_pkg::*;

  localparam int LW = $clog2(MAX_FRAME + 1);
  localparam int IW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_OUT   = 2'd2;

  logic [1:0]    state;

  // frame state
  logic [LW-1:0] length;
  logic [7:0]    run_sum;
  logic [1:0]    wake_count;
  logic          wake_flag;
  byte_t         head [PATTERN_BYTES];

  // result waiting for the output register
  logic [2:0]    pend_event;
  logic [1:0]    pend_index;
  logic [6:0]    pend_len;

  cfg_t          cfg;
  match_res_t    mres;
  logic          match_start;
  logic [LW-1:0] match_len;

  logic          accept;
  logic [LW-1:0] len_inc;
  logic          is_wake;
  logic          is_header;
  logic          frame_end;
  logic          overflow;
  logic [1:0]    wake_count_next;

  kfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kfr_prefix_matcher #(
    .MAX_FRAME     (MAX_FRAME),
    .NUM_PATTERNS  (NUM_PATTERNS),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .start     (match_start),
    .frame_len (match_len),
    .cfg       (cfg),
    .head      (head),
    .res       (mres)
  );

  assign rx_ready = (state == S_IDLE);
  assign accept   = rx_valid && rx_ready;

  // byte classification, all against the state before this byte
  always_comb begin
    len_inc         = length + 1'b1;
    is_wake         = (length == '0) && (rx_byte == 8'h00);
    is_header       = (length == '0) && (rx_byte == HEADER_BYTE);
    // checksum byte equals the sum of everything before it
    frame_end       = (rx_byte == run_sum) && (len_inc > LW'(MIN_END_LEN));
    overflow        = (len_inc >= LW'(MAX_FRAME));
    wake_count_next = (wake_count < WAKE_LIMIT) ? wake_count + 1'b1 : wake_count;
  end

  // first bytes of the frame, no reset: only entries of the live frame are read
  always_ff @(posedge clk) begin
    if (accept && !is_wake && !is_header && (length < LW'(PATTERN_BYTES))) begin
      head[length[IW-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      length      <= '0;
      run_sum     <= '0;
      wake_count  <= '0;
      wake_flag   <= 1'b0;
      res_valid   <= 1'b0;
      match_start <= 1'b0;
    end else begin
      // the compare's start strobe is registered from the accept of a frame-ending byte
      match_start <= accept && !is_wake && !is_header && frame_end;
      if ((state == S_OUT) && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend_index <= 2'd0;
            if (is_wake) begin
              wake_count <= wake_count_next;
              if (wake_count_next == WAKE_LIMIT) begin
                wake_flag <= 1'b1;
              end
              pend_event <= EV_WAKE;
              pend_len   <= '0;
              state      <= S_OUT;
            end else if (is_header) begin
              pend_event <= EV_HEADER;
              pend_len   <= '0;
              state      <= S_OUT;
            end else if (frame_end) begin
              // frame empties now; the compare works from the latched length
              length      <= '0;
              run_sum     <= '0;
              match_len   <= len_inc;
              pend_len    <= '0;
              state       <= S_MATCH;
            end else if (overflow) begin
              length     <= '0;
              run_sum    <= '0;
              pend_event <= EV_OVERFLOW;
              pend_len   <= '0;
              state      <= S_OUT;
            end else begin
              length     <= len_inc;
              run_sum    <= run_sum + rx_byte;
              pend_event <= EV_STORED;
              pend_len   <= 7'(len_inc);
              state      <= S_OUT;
            end
          end
        end
        S_MATCH: begin
          if (mres.done) begin
            pend_event <= mres.hit ? EV_MATCH : EV_NOMATCH;
            pend_index <= mres.hit ? mres.index : 2'd0;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            event_res    <= pend_event;
            match_index  <= pend_index;
            wake_active  <= wake_flag;
            frame_length <= pend_len;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // one item in flight: no accept right after an accept
  assert property (@(posedge clk) disable iff (rst) accept |=> !rx_ready)
    else $error("item accepted while previous item still in work");

  assert property (@(posedge clk) disable iff (rst) res_valid |-> frame_length < MAX_FRAME)
    else $error("reported frame length reaches the frame limit");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && (event_res != EV_MATCH)) |-> (match_index == 2'd0))
    else $error("match index set without a match");

  assert property (@(posedge clk) disable iff (rst) $past(wake_flag) |-> wake_flag)
    else $error("wake flag cleared outside reset");

  assert property (@(posedge clk) disable iff (rst) mres.done |-> (state == S_MATCH))
    else $error("compare finished while no frame end pending");

endmodule
